// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the RTL files.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/swq_pkg.sv -----
`default_nettype none

package swq_pkg;

  // Table geometry.
  localparam int unsigned SLOTS    = 16;
  localparam int unsigned ID_WIDTH = 8;
  localparam int unsigned CNT_W    = $clog2(SLOTS + 1);
  localparam int unsigned IDX_W    = $clog2(SLOTS);

  // Port field widths.
  localparam int unsigned TASK_W = 8;
  localparam int unsigned TICK_W = 63;
  localparam int unsigned KIND_W = 2;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  typedef enum logic [0:0] {
    CMD_SLEEP = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_WOKEN  = 2'd1,
    KIND_NONE   = 2'd2,
    KIND_FULL   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // One table entry as held in the slot memory.
  typedef struct packed {
    logic [ID_WIDTH-1:0] id;
    logic [TICK_W-1:0]   wake;
  } slot_t;

endpackage

`default_nettype wire

// ----- rtl/core/swq_in_if.sv -----
`default_nettype none

// Command channel: sleep requests and timer ticks.
interface swq_in_if import swq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [0:0]        command;
  logic [TASK_W-1:0] task_id;
  logic [TICK_W-1:0] tick_value;

  modport source (output valid, command, task_id, tick_value, input ready);
  modport sink   (input valid, command, task_id, tick_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/swq_out_if.sv -----
`default_nettype none

// Result channel: acknowledgements, woken ids and status.
interface swq_out_if import swq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TASK_W-1:0] woken_id;
  logic [TICK_W-1:0] earliest_wake;
  logic              last;

  modport source (output valid, kind, woken_id, earliest_wake, last, input ready);
  modport sink   (input valid, kind, woken_id, earliest_wake, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sleep_wakeup_queue_top.sv -----
// Sleep queue with earliest-wakeup tick. Up to SLOTS sleeping tasks are kept in
// insertion order in a slot memory, each with an absolute wake tick. A sleep
// item answers one result (accepted, or table full when
// all slots are in use). A tick item walks the table through the slot memory's
// single read port, one entry per cycle, compacting the surviving entries in
// place and collecting woken ids in a small buffer. The results follow
// afterwards, since every one of them carries the recomputed earliest wake
// tick: a single result for a tick that wakes nothing, else one result per
// woken task, each read through the buffer's registered read before the next.
// A new item is taken only once all results of the previous one have been
// handed to the output register.
`default_nettype none

`include "assert_macros.svh"

module sleep_wakeup_queue_top import swq_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  swq_in_if.sink      in_s,
  swq_out_if.source   out_s
);

  // Control state.
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q;
  logic [TICK_W-1:0]  earliest_q;
  logic [TICK_W-1:0]  tick_q;
  logic [CNT_W-1:0]   rd_idx_q;
  logic [CNT_W-1:0]   keep_q;
  logic [CNT_W-1:0]   nwk_q;
  logic [CNT_W-1:0]   emit_idx_q;
  logic               vld_q;
  logic               rd_pend_q;

  // Output register.
  logic               out_vld_q;
  kind_e              out_kind_q;
  logic [TASK_W-1:0]  out_id_q;
  logic [TICK_W-1:0]  out_early_q;
  logic               out_last_q;

  // Memories and their read data.
  slot_t              slot_mem [SLOTS];
  logic [ID_WIDTH-1:0] woken_mem [SLOTS];
  slot_t              slot_rd_q;
  logic [ID_WIDTH-1:0] woken_rd_q;

  // Combinational strobes.
  logic               out_free;
  logic               accept;
  logic               is_sleep;
  logic               full;
  logic [TICK_W-1:0]  sleep_min;
  logic               scan_issue;
  logic               scan_done;
  logic               wakes;
  logic               emit_issue;
  logic               none_load;
  logic               woken_last;

  // Handshake and command decode.
  always_comb begin
    out_free   = !out_vld_q || out_s.ready;
    in_s.ready = (state_q == ST_IDLE) && out_free;
    accept     = in_s.valid && in_s.ready;
    is_sleep   = cmd_e'(in_s.command) == CMD_SLEEP;
    full       = cnt_q == CNT_W'(SLOTS);
    sleep_min  = (in_s.tick_value < earliest_q) ? in_s.tick_value : earliest_q;
  end

  // Scan and emit strobes.
  always_comb begin
    scan_issue = (state_q == ST_SCAN) && (rd_idx_q < cnt_q);
    scan_done  = (state_q == ST_SCAN) && !scan_issue && !vld_q;
    wakes      = slot_rd_q.wake <= tick_q;
    emit_issue = (state_q == ST_EMIT) && (nwk_q != '0) && (emit_idx_q < nwk_q) &&
                 !rd_pend_q && out_free;
    none_load  = (state_q == ST_EMIT) && (nwk_q == '0) && out_free;
    woken_last = emit_idx_q == nwk_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !is_sleep) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (none_load || (rd_pend_q && woken_last)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      earliest_q <= TICK_MAX;
      rd_idx_q   <= '0;
      keep_q     <= '0;
      nwk_q      <= '0;
      emit_idx_q <= '0;
      vld_q      <= 1'b0;
      rd_pend_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      vld_q     <= scan_issue;
      rd_pend_q <= emit_issue;
      if (accept && is_sleep && !full) begin
        cnt_q      <= cnt_q + CNT_W'(1);
        earliest_q <= sleep_min;
      end
      if (accept && !is_sleep) begin
        earliest_q <= TICK_MAX;
        rd_idx_q   <= '0;
        keep_q     <= '0;
        nwk_q      <= '0;
      end
      if (scan_issue) rd_idx_q <= rd_idx_q + CNT_W'(1);
      if (vld_q) begin
        if (wakes) begin
          nwk_q <= nwk_q + CNT_W'(1);
        end else begin
          keep_q <= keep_q + CNT_W'(1);
          if (slot_rd_q.wake < earliest_q) earliest_q <= slot_rd_q.wake;
        end
      end
      if (scan_done) begin
        cnt_q      <= keep_q;
        emit_idx_q <= '0;
      end
      if (emit_issue) emit_idx_q <= emit_idx_q + CNT_W'(1);
    end
  end

  // Tick latch for the scan compare.
  always_ff @(posedge clk_i) begin
    if (accept) tick_q <= in_s.tick_value;
  end

  // Slot memory: appends on sleep, compaction writes during a scan.
  // The compaction write address never passes the read address.
  always_ff @(posedge clk_i) begin
    if (accept && is_sleep && !full) begin
      slot_mem[cnt_q[IDX_W-1:0]] <= '{id: ID_WIDTH'(in_s.task_id), wake: in_s.tick_value};
    end else if (vld_q && !wakes) begin
      slot_mem[keep_q[IDX_W-1:0]] <= slot_rd_q;
    end
    if (scan_issue) slot_rd_q <= slot_mem[rd_idx_q[IDX_W-1:0]];
  end

  // Woken id buffer: filled during the scan, drained in the emit phase.
  always_ff @(posedge clk_i) begin
    if (vld_q && wakes) woken_mem[nwk_q[IDX_W-1:0]] <= slot_rd_q.id;
    if (emit_issue) woken_rd_q <= woken_mem[emit_idx_q[IDX_W-1:0]];
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if ((accept && is_sleep) || none_load || rd_pend_q) begin
      out_vld_q <= 1'b1;
    end else if (out_s.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (accept && is_sleep) begin
      out_kind_q  <= full ? KIND_FULL : KIND_ACCEPT;
      out_id_q    <= '0;
      out_early_q <= full ? earliest_q : sleep_min;
      out_last_q  <= 1'b1;
    end else if (none_load) begin
      out_kind_q  <= KIND_NONE;
      out_id_q    <= '0;
      out_early_q <= earliest_q;
      out_last_q  <= 1'b1;
    end else if (rd_pend_q) begin
      out_kind_q  <= KIND_WOKEN;
      out_id_q    <= TASK_W'(woken_rd_q);
      out_early_q <= earliest_q;
      out_last_q  <= woken_last;
    end
  end

  // Result port.
  always_comb begin
    out_s.valid         = out_vld_q;
    out_s.kind          = out_kind_q;
    out_s.woken_id      = out_id_q;
    out_s.earliest_wake = out_early_q;
    out_s.last          = out_last_q;
  end

  // The occupancy count never exceeds the table depth.
  `SWQ_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(SLOTS), "occupancy above table depth")

  // Every entry read during a scan is either kept or woken, none twice.
  `SWQ_ASSERT_SAME(a_scan_balance, state_q == ST_SCAN, (CNT_W+1)'(keep_q) + (CNT_W+1)'(nwk_q) + (CNT_W+1)'(vld_q) == (CNT_W+1)'(rd_idx_q), "scan bookkeeping out of step")

  // A buffered id read never meets an occupied output register.
  `SWQ_ASSERT_SAME(a_no_overrun, rd_pend_q, !out_vld_q, "woken id would overwrite a waiting result")

  // Results other than woken ids are always the single, final one.
  `SWQ_ASSERT_SAME(a_single_last, out_vld_q && (out_kind_q != KIND_WOKEN), out_last_q, "single result without last")

  // Leaving the scan, the kept entries become the new occupancy.
  `SWQ_ASSERT_NEXT(a_cnt_after_scan, scan_done, cnt_q == $past(keep_q), "occupancy not updated after scan")

endmodule

`default_nettype wire

// ----- verif/swq_checker.sv -----
`default_nettype none

// Watches both channels of the sleep queue, predicts the results of every
// accepted command and compares them in order with the results handed out.
module swq_checker import swq_pkg::*; (
  input  wire clk_i,
  input  wire rst_ni,
  swq_in_if   in_w,
  swq_out_if  out_w,
  output int  errors_o,
  output int  pending_o,
  output int  results_o,
  output int  woken_o,
  output int  full_o
);

  typedef struct packed {
    kind_e             kind;
    logic [TASK_W-1:0] id;
    logic [TICK_W-1:0] wake;
    logic              last;
  } result_t;

  // Predicted copy of the sleep table, kept in insertion order.
  logic [ID_WIDTH-1:0] sleeper_id   [SLOTS];
  logic [TICK_W-1:0]   sleeper_wake [SLOTS];
  int unsigned         sleepers;
  logic [TICK_W-1:0]   earliest_wake;

  result_t due_results [$];

  // Applies one command to the predicted table and queues its results.
  task automatic predict_wakeups(input cmd_e cmd, input logic [TASK_W-1:0] id,
                                 input logic [TICK_W-1:0] tick);
    logic [TASK_W-1:0] woke_ids [$];
    int unsigned       keep;
    result_t           res;
    keep = 0;
    res  = '0;
    if (cmd == CMD_SLEEP) begin
      if (sleepers >= SLOTS) begin
        res.kind = KIND_FULL;
      end else begin
        sleeper_id[sleepers]   = ID_WIDTH'(id);
        sleeper_wake[sleepers] = tick;
        sleepers++;
        if (earliest_wake > tick) earliest_wake = tick;
        res.kind = KIND_ACCEPT;
      end
      res.wake = earliest_wake;
      res.last = 1'b1;
      due_results.push_back(res);
    end else begin
      // Walk the table, pull out due entries and compact the survivors.
      earliest_wake = TICK_MAX;
      for (int i = 0; i < sleepers; i++) begin
        if (sleeper_wake[i] <= tick) begin
          woke_ids.push_back(TASK_W'(sleeper_id[i]));
        end else begin
          if (earliest_wake > sleeper_wake[i]) earliest_wake = sleeper_wake[i];
          sleeper_id[keep]   = sleeper_id[i];
          sleeper_wake[keep] = sleeper_wake[i];
          keep++;
        end
      end
      sleepers = keep;
      if (woke_ids.size() == 0) begin
        res.kind = KIND_NONE;
        res.wake = earliest_wake;
        res.last = 1'b1;
        due_results.push_back(res);
      end else begin
        foreach (woke_ids[k]) begin
          res.kind = KIND_WOKEN;
          res.id   = woke_ids[k];
          res.wake = earliest_wake;
          res.last = (k == woke_ids.size() - 1);
          due_results.push_back(res);
        end
      end
    end
  endtask

  // Sample both handshakes at the clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      sleepers      = 0;
      earliest_wake = TICK_MAX;
      due_results.delete();
    end else begin
      if (out_w.valid && out_w.ready) begin
        results_o++;
        if (due_results.size() == 0) begin
          $error("result with nothing expected: kind %0d, woken_id %0d, earliest_wake %0h",
                 out_w.kind, out_w.woken_id, out_w.earliest_wake);
          errors_o++;
        end else begin
          want = due_results.pop_front();
          if (want.kind == KIND_WOKEN) woken_o++;
          if (want.kind == KIND_FULL) full_o++;
          if (out_w.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_w.kind);
            errors_o++;
          end
          if (out_w.woken_id !== want.id) begin
            $error("woken_id: expected %0d, actual %0d", want.id, out_w.woken_id);
            errors_o++;
          end
          if (out_w.earliest_wake !== want.wake) begin
            $error("earliest_wake: expected %0h, actual %0h", want.wake,
                   out_w.earliest_wake);
            errors_o++;
          end
          if (out_w.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, out_w.last);
            errors_o++;
          end
        end
      end
      if (in_w.valid && in_w.ready) begin
        predict_wakeups(cmd_e'(in_w.command), in_w.task_id, in_w.tick_value);
      end
    end
    pending_o = due_results.size();
  end

endmodule

`default_nettype wire

// ----- verif/sleep_wakeup_queue_top_tb.sv -----
`default_nettype none

// Drives sleep and tick commands into the sleep queue with random gaps and
// output stalls; the checker beside the block does the prediction.
module sleep_wakeup_queue_top_tb import swq_pkg::*; ();

  localparam int unsigned RANDOM_ITEMS = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 3 * SLOTS + 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  swq_in_if  in_s ();
  swq_out_if out_s ();

  int errors;
  int pending;
  int results;
  int woken;
  int fulls;

  int unsigned     cycles = 0;
  int unsigned     sent   = 0;
  int unsigned     directed;
  int unsigned     random_sent;
  bit              send_calm = 1'b0;
  bit              take_calm = 1'b0;
  logic [TICK_W-1:0] now_tick;

  sleep_wakeup_queue_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_s   (in_s),
    .out_s  (out_s)
  );

  swq_checker check_u (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_w      (in_s),
    .out_w     (out_s),
    .errors_o  (errors),
    .pending_o (pending),
    .results_o (results),
    .woken_o   (woken),
    .full_o    (fulls)
  );

  // Clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Guard against a hung block.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.", cycles,
               pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [TICK_W-1:0] any_tick();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TICK_W-1:0];
  endfunction

  // Hands one command to the block after a random gap.
  task automatic issue(input cmd_e cmd, input logic [TASK_W-1:0] id,
                       input logic [TICK_W-1:0] tick);
    int unsigned gap;
    gap = send_calm ? 0 : $urandom_range(0, 7);
    if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
    if (gap != 0) begin
      in_s.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_s.valid      <= 1'b1;
    in_s.command    <= cmd;
    in_s.task_id    <= id;
    in_s.tick_value <= tick;
    do @(posedge clk_i); while (!in_s.ready);
    sent++;
  endtask

  // A sleep due shortly, sometimes already overdue.
  task automatic sleep_soon();
    logic [TICK_W-1:0] wake;
    if ($urandom_range(0, 9) == 0) wake = now_tick - TICK_W'($urandom_range(0, 20));
    else wake = now_tick + TICK_W'($urandom_range(0, 60));
    issue(CMD_SLEEP, TASK_W'($urandom), wake);
  endtask

  // Result side: stall a random number of cycles before taking each item.
  initial begin
    int unsigned stall;
    out_s.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = take_calm ? 0 : $urandom_range(0, 7);
      if ($urandom_range(0, 29) == 0) take_calm = !take_calm;
      if (stall != 0) begin
        out_s.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_s.ready <= 1'b1;
      do @(posedge clk_i); while (!out_s.valid);
    end
  end

  // Command side: directed cases, then random traffic, then the verdict.
  initial begin
    int unsigned pick;
    in_s.valid      <= 1'b0;
    in_s.command    <= CMD_SLEEP;
    in_s.task_id    <= '0;
    in_s.tick_value <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Tick on an empty table, then the extremes of id and wake tick.
    issue(CMD_TICK, '1, TICK_MAX);
    issue(CMD_SLEEP, '0, '0);
    issue(CMD_SLEEP, '1, TICK_MAX);
    issue(CMD_TICK, 8'h5a, '0);
    issue(CMD_TICK, '0, TICK_MAX);

    // Fill every slot, overflow once, then wake in two groups.
    for (int i = 0; i < SLOTS; i++) begin
      issue(CMD_SLEEP, TASK_W'(i * 17), (i % 2) ? 63'd150 : 63'd300 + TICK_W'(i));
    end
    issue(CMD_SLEEP, 8'hc3, 63'd1);
    issue(CMD_TICK, '0, 63'd200);
    issue(CMD_TICK, '1, 63'd400);
    directed = sent;

    // Random traffic around a moving current tick.
    now_tick = (any_tick() >> 2) + 63'd1000;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // A run of sleeps that can reach or pass a full table.
        repeat ($urandom_range(SLOTS - 4, SLOTS + 3)) sleep_soon();
      end else if (pick < 55) begin
        sleep_soon();
      end else if (pick < 90) begin
        now_tick = now_tick + TICK_W'($urandom_range(0, 30));
        issue(CMD_TICK, TASK_W'($urandom), now_tick);
      end else if (pick < 95) begin
        issue(CMD_SLEEP, TASK_W'($urandom), any_tick());
      end else begin
        issue(CMD_TICK, TASK_W'($urandom), any_tick());
      end
      random_sent = sent - directed;
    end
    in_s.valid <= 1'b0;

    // Drain outstanding results, then give the block time to misbehave.
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Sent %0d commands (%0d directed); checked %0d results,", sent, directed,
             results);
    $display("including %0d woken tasks and %0d table-full answers.", woken, fulls);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl/core
rtl/core/swq_pkg.sv
rtl/core/swq_in_if.sv
rtl/core/swq_out_if.sv
rtl/core/sleep_wakeup_queue_top.sv
verif/swq_checker.sv
verif/sleep_wakeup_queue_top_tb.sv
